[rtl/core/keyword_substitution_cipher_macros.svh]
// ----------------------------------------------------------------------------
// Keyword substitution cipher: assertion macros
// Clocked property checks with reset qualification, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every rising edge outside reset.
`define KCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that expr is never true outside reset.
`define KCS_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCS_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/core/kcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_pkg
// Types and constants shared by the keyword substitution cipher.
// ----------------------------------------------------------------------------
package kcs_pkg;

	localparam int unsigned AlphaCount = 26;
	localparam int unsigned IdxW       = 5;

	localparam logic [1:0] OP_KEY    = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_ENC    = 2'd2;
	localparam logic [1:0] OP_DEC    = 2'd3;

	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;

	localparam logic [IdxW-1:0]       LAST_IDX    = IdxW'(AlphaCount - 1);
	localparam logic [IdxW-1:0]       FILL_FULL   = IdxW'(AlphaCount);
	localparam logic [AlphaCount-1:0] ALL_LETTERS = '1;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic walk;
		logic walk_end;
	} kcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic loading;
		logic walk_last;
	} kcs_sts_t;

endpackage

[rtl/core/kcs_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_dpath
// Cipher tables, keyword fill state, walk counter and result register.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_macros.svh"

module kcs_dpath import kcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  kcs_cmd_t ctl,
	input  cmd_t     cmd,
	output kcs_sts_t sts,
	output rsp_t     rsp
);

	logic [IdxW-1:0]       fwd_q [AlphaCount];
	logic [IdxW-1:0]       inv_q [AlphaCount];
	logic [AlphaCount-1:0] used_q;
	logic [IdxW-1:0]       fill_q;
	logic                  ready_q;
	logic [IdxW-1:0]       walk_idx_q;
	rsp_t                  rsp_q;

	logic                  is_upper;
	logic                  is_lower;
	logic                  is_letter;
	logic [IdxW-1:0]       li;
	logic [AlphaCount-1:0] used_eff;
	logic [IdxW-1:0]       fill_eff;
	logic                  app;
	logic [IdxW-1:0]       app_letter;
	logic [IdxW-1:0]       app_pos;
	logic [AlphaCount-1:0] used_nxt;
	logic [IdxW-1:0]       fill_nxt;
	logic                  ready_nxt;
	rsp_t                  rsp_nxt;

	always_comb begin
		is_upper  = (cmd.data_byte >= CH_UA) && (cmd.data_byte <= CH_UZ);
		is_lower  = (cmd.data_byte >= CH_LA) && (cmd.data_byte <= CH_LZ);
		is_letter = is_upper || is_lower;
		if (is_upper) begin
			li = IdxW'(cmd.data_byte - CH_UA);
		end else if (is_lower) begin
			li = IdxW'(cmd.data_byte - CH_LA);
		end else begin
			li = '0;
		end
		// a keyword byte while the table is complete opens a fresh keyword
		used_eff = ready_q ? '0 : used_q;
		fill_eff = ready_q ? '0 : fill_q;
	end

	always_comb begin
		used_nxt   = used_q;
		fill_nxt   = fill_q;
		ready_nxt  = ready_q;
		app        = 1'b0;
		app_letter = li;
		app_pos    = fill_eff;
		if (ctl.take && (cmd.operation == OP_KEY)) begin
			used_nxt  = used_eff;
			fill_nxt  = fill_eff;
			ready_nxt = 1'b0;
			app       = is_letter && !used_eff[li] && (fill_eff < FILL_FULL);
		end
		if (ctl.walk) begin
			app_letter = walk_idx_q;
			app_pos    = fill_q;
			app        = !used_q[walk_idx_q] && (fill_q < FILL_FULL);
		end
		if (app) begin
			used_nxt[app_letter] = 1'b1;
			fill_nxt             = app_pos + IdxW'(1);
		end
		if (ctl.walk_end) begin
			used_nxt  = ALL_LETTERS;
			fill_nxt  = FILL_FULL;
			ready_nxt = 1'b1;
		end
	end

	always_comb begin
		rsp_nxt = '0;
		if (ctl.take) begin
			unique case (cmd.operation) inside
				OP_ENC, OP_DEC: begin
					if (!ready_q) begin
						rsp_nxt.out_byte = cmd.data_byte;
						rsp_nxt.status   = 1'b1;
					end else if (!is_letter) begin
						rsp_nxt.out_byte = cmd.data_byte;
					end else if (cmd.operation == OP_ENC) begin
						rsp_nxt.out_byte = CH_UA + {3'b000, fwd_q[li]};
					end else begin
						rsp_nxt.out_byte = CH_UA + {3'b000, inv_q[li]};
					end
				end
				default: rsp_nxt = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AlphaCount; i++) begin
				fwd_q[i] <= IdxW'(i);
				inv_q[i] <= IdxW'(i);
			end
			used_q     <= ALL_LETTERS;
			fill_q     <= FILL_FULL;
			ready_q    <= 1'b1;
			walk_idx_q <= '0;
		end else begin
			if (app) begin
				fwd_q[app_pos]    <= app_letter;
				inv_q[app_letter] <= app_pos;
			end
			used_q  <= used_nxt;
			fill_q  <= fill_nxt;
			ready_q <= ready_nxt;
			// restart the letter walk on every accepted word, advance while walking
			if (ctl.take) begin
				walk_idx_q <= '0;
			end else if (ctl.walk) begin
				walk_idx_q <= walk_idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take || ctl.walk_end) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign sts.loading   = !ready_q;
	assign sts.walk_last = (walk_idx_q == LAST_IDX);
	assign rsp           = rsp_q;

	`KCS_ASSERT(a_ready_full, clk, arst_n, ready_q |-> (used_q == ALL_LETTERS) && (fill_q == FILL_FULL), "complete table with letters missing")
	`KCS_ASSERT(a_end_ready, clk, arst_n, ctl.walk_end |=> ready_q && (fill_q == FILL_FULL), "walk ended without a full table")
	`KCS_NEVER(a_walk_ready, clk, arst_n, ctl.walk && ready_q, "letter walk on a complete table")

endmodule

[rtl/core/kcs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_ctrl
// Handshake control and letter walk sequencing for the finish operation.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_macros.svh"

module kcs_ctrl import kcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] operation,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  kcs_sts_t   sts,
	output kcs_cmd_t   ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q;
	logic state_nxt;
	logic rsp_valid_q;
	logic start_walk;

	always_comb begin
		cmd_stall    = (state_q == ST_WALK) || (rsp_valid_q && rsp_stall);
		ctl.take     = cmd_valid && !cmd_stall;
		start_walk   = ctl.take && (operation == OP_FINISH) && sts.loading;
		ctl.walk     = (state_q == ST_WALK);
		ctl.walk_end = (state_q == ST_WALK) && sts.walk_last;
		state_nxt    = state_q;
		unique case (state_q)
			ST_IDLE: if (start_walk) state_nxt = ST_WALK;
			ST_WALK: if (sts.walk_last) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the word until taken; finish while loading reports after the walk
			if ((ctl.take && !start_walk) || ctl.walk_end) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`KCS_NEVER(a_walk_rsp, clk, arst_n, (state_q == ST_WALK) && rsp_valid_q, "result pending during walk")
	`KCS_ASSERT(a_end_rsp, clk, arst_n, ctl.walk_end |=> rsp_valid_q, "walk ended without a result")
	`KCS_ASSERT(a_start_walk, clk, arst_n, start_walk |=> (state_q == ST_WALK) && !rsp_valid_q, "finish did not start the walk")

endmodule

[rtl/core/keyword_substitution_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword alphabet builder and substitution cipher, top level.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per item: operation (keyword byte, finish, encrypt,
//   decrypt) and data_byte. rsp carries one word per item: out_byte and
//   status. Both channels use valid/stall; a word moves when valid is high
//   and stall is low.
//   Keyword, encrypt, decrypt and finish on a complete table give their
//   result in the cycle after acceptance, and one item is taken per cycle
//   while rsp_stall is low. Finish while a keyword is loading walks the 26
//   letters one per cycle, and its result appears after the walk; cmd is
//   stalled for the walk.
//   The result sits in an output register: the next word is taken in the
//   same cycle the pending result is taken. While rsp_stall holds the
//   result, cmd_stall is raised.
//   Reset leaves the identity table complete and no result pending.
// ----------------------------------------------------------------------------

module keyword_substitution_cipher import kcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	kcs_cmd_t ctl;
	kcs_sts_t sts;

	kcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.operation (cmd.operation),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	kcs_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
